>>> rtl/rosl_pkg.sv
// shared types and constants for the ray against oriented box slab test
package rosl_pkg;

  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 15;
  localparam int T_W       = 32;
  localparam int H_W       = 31;
  localparam int EPS_W     = 16;
  localparam int PROD_W    = AXIS_W + T_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DOT_W     = ACC_W - AXIS_FRAC;
  localparam int NUM_W     = DOT_W + 1;
  localparam int QUO_W     = T_W + 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;
  localparam logic signed [T_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [T_W-1:0] T_MIN = 32'sh8000_0000;

  // register index taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_EPS = 1'b0;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic        [H_W-1:0]    half_extent;
    logic signed [T_W-1:0]    to_center_x;
    logic signed [T_W-1:0]    to_center_y;
    logic signed [T_W-1:0]    to_center_z;
    logic signed [T_W-1:0]    ray_dir_x;
    logic signed [T_W-1:0]    ray_dir_y;
    logic signed [T_W-1:0]    ray_dir_z;
    logic                     last_axis;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic signed [T_W-1:0] t_near;
    logic signed [T_W-1:0] t_far;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic clr;
  } dot_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic signed [T_W-1:0] quo;
  } div_resp_t;

endpackage

>>> rtl/rosl_dot_unit.sv
// shared multiply-accumulate unit forming one dot product from three products
module rosl_dot_unit (
  input  logic                                 clk,
  input  rosl_pkg::dot_ctrl_t                  ctrl,
  input  logic signed [rosl_pkg::AXIS_W-1:0]   a,
  input  logic signed [rosl_pkg::T_W-1:0]      b,
  output logic signed [rosl_pkg::DOT_W-1:0]    dot
);

  logic signed [rosl_pkg::PROD_W-1:0] prod;
  logic signed [rosl_pkg::ACC_W-1:0]  prod_ext;
  logic signed [rosl_pkg::ACC_W-1:0]  acc_r;
  logic signed [rosl_pkg::ACC_W-1:0]  acc_nxt;

  assign prod     = a * b;
  assign prod_ext = $signed({{(rosl_pkg::ACC_W - rosl_pkg::PROD_W){prod[rosl_pkg::PROD_W-1]}},
                             prod});

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.en) begin
      acc_nxt = ctrl.clr ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // dropping the low bits of a two's complement sum rounds toward minus infinity
  assign dot = $signed(acc_r[rosl_pkg::ACC_W-1:rosl_pkg::AXIS_FRAC]);

endmodule

>>> rtl/rosl_div_unit.sv
// radix-2 restoring divider: saturated fixed-point quotient, one bit a cycle
module rosl_div_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [rosl_pkg::NUM_W-1:0]   num,
  input  logic signed [rosl_pkg::DOT_W-1:0]   den,
  output rosl_pkg::div_resp_t                 resp
);

  localparam int SCL_W = rosl_pkg::NUM_W + FRAC_BITS;
  localparam int HI_W  = SCL_W - rosl_pkg::QUO_W;
  localparam int CMP_W = (HI_W > rosl_pkg::DOT_W) ? HI_W : rosl_pkg::DOT_W;
  localparam int CNT_W = $clog2(rosl_pkg::QUO_W);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_PREP = 4'b0010,
    D_RUN  = 4'b0100,
    D_DONE = 4'b1000
  } div_state_t;

  div_state_t                       dst_r, dst_nxt;
  logic [rosl_pkg::NUM_W-1:0]       mag_r;
  logic [rosl_pkg::DOT_W-1:0]       d_r;
  logic                             neg_r;
  logic                             ovf_r;
  logic [rosl_pkg::DOT_W-1:0]       rem_r;
  logic [rosl_pkg::QUO_W-1:0]       low_r;
  logic [rosl_pkg::QUO_W-1:0]       q_r;
  logic [CNT_W-1:0]                 cnt_r;

  logic [rosl_pkg::NUM_W-1:0]       num_mag;
  logic [rosl_pkg::DOT_W-1:0]       den_mag;
  logic [SCL_W-1:0]                 scaled;
  logic [HI_W-1:0]                  hi;
  logic                             ovf;
  logic [rosl_pkg::DOT_W:0]         trial;
  logic [rosl_pkg::DOT_W:0]         diff;
  logic                             fits;
  logic                             sat;
  logic [rosl_pkg::T_W-1:0]         q_low;

  assign num_mag = num[rosl_pkg::NUM_W-1] ? rosl_pkg::NUM_W'(-num) : rosl_pkg::NUM_W'(num);
  assign den_mag = den[rosl_pkg::DOT_W-1] ? rosl_pkg::DOT_W'(-den) : rosl_pkg::DOT_W'(den);

  assign scaled = {mag_r, {FRAC_BITS{1'b0}}};
  assign hi     = scaled[SCL_W-1:rosl_pkg::QUO_W];
  // quotient of 2^33 or more saturates either way, so only 33 bits are developed
  assign ovf    = CMP_W'(hi) >= CMP_W'(d_r);

  assign trial = {rem_r, low_r[rosl_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    dst_nxt = dst_r;
    case (dst_r)
      D_IDLE:  if (start) dst_nxt = D_PREP;
      D_PREP:  dst_nxt = ovf ? D_DONE : D_RUN;
      D_RUN:   if (cnt_r == CNT_W'(rosl_pkg::QUO_W - 1)) dst_nxt = D_DONE;
      D_DONE:  dst_nxt = start ? D_PREP : D_IDLE;
      default: dst_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r <= D_IDLE;
    end else begin
      dst_r <= dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && ((dst_r == D_IDLE) || (dst_r == D_DONE))) begin
      mag_r <= num_mag;
      d_r   <= den_mag;
      neg_r <= num[rosl_pkg::NUM_W-1] ^ den[rosl_pkg::DOT_W-1];
    end
    if (dst_r == D_PREP) begin
      ovf_r <= ovf;
      rem_r <= rosl_pkg::DOT_W'(hi);
      low_r <= scaled[rosl_pkg::QUO_W-1:0];
      q_r   <= '0;
      cnt_r <= '0;
    end
    if (dst_r == D_RUN) begin
      rem_r <= fits ? diff[rosl_pkg::DOT_W-1:0] : trial[rosl_pkg::DOT_W-1:0];
      low_r <= {low_r[rosl_pkg::QUO_W-2:0], 1'b0};
      q_r   <= {q_r[rosl_pkg::QUO_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sat   = ovf_r || (q_r[rosl_pkg::QUO_W-1:rosl_pkg::QUO_W-2] != 2'b00);
  assign q_low = q_r[rosl_pkg::T_W-1:0];

  always_comb begin
    resp.done = (dst_r == D_DONE);
    if (sat) begin
      resp.quo = neg_r ? rosl_pkg::T_MIN : rosl_pkg::T_MAX;
    end else begin
      resp.quo = neg_r ? $signed(-q_low) : $signed(q_low);
    end
  end

endmodule

>>> rtl/ray_obb_slab_test_top.sv
// top level of the ray against oriented box slab test with its register port
//
// One item carries one box axis; an item with last_axis set closes the box and
// yields one result (hit, t_near, t_far), after which the interval restarts at
// [0, max]. The block takes one item at a time and stalls its input while it
// works. A slab that the ray crosses uses the shared 16x32 multiply-accumulate
// for the two dot products, then two quotients on the one radix-2 divider (33
// quotient bits plus setup and finish), with the decide, update and finish
// control states around them. A slab the ray runs parallel to skips the
// divider, and an axis after a miss skips all arithmetic. A result waits in
// an output register, so the next box can start while it is stalled. The
// parallel_epsilon register sits at byte address 0 and may be written only
// while the block is idle.
module ray_obb_slab_test_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rosl_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rosl_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rosl_pkg::PADDR_W-1:0]      paddr,
  input  logic [rosl_pkg::PDATA_W-1:0]      pwdata,
  output logic [rosl_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DOT    = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_DIV1   = 7'b0001000,
    ST_DIV2   = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t                                  state_r, state_nxt;
  logic [2:0]                              step_r;
  rosl_pkg::in_item_t                      item_r;
  logic signed [rosl_pkg::DOT_W-1:0]       e_r;
  logic signed [rosl_pkg::T_W-1:0]         q1_r;
  logic signed [rosl_pkg::T_W-1:0]         q2_r;
  logic signed [rosl_pkg::T_W-1:0]         near_r;
  logic signed [rosl_pkg::T_W-1:0]         far_r;
  logic                                    missed_r;
  logic [rosl_pkg::EPS_W-1:0]              eps_r;
  logic                                    out_valid_r;
  rosl_pkg::out_item_t                     out_r;

  rosl_pkg::dot_ctrl_t                     dot_ctrl;
  logic signed [rosl_pkg::AXIS_W-1:0]      op_a;
  logic signed [rosl_pkg::T_W-1:0]         op_b;
  logic signed [rosl_pkg::DOT_W-1:0]       dot_val;
  logic [rosl_pkg::DOT_W-1:0]              f_mag;
  logic                                    steep;
  logic signed [rosl_pkg::NUM_W-1:0]       e_ext;
  logic signed [rosl_pkg::NUM_W-1:0]       h_ext;
  logic signed [rosl_pkg::NUM_W-1:0]       num_p;
  logic signed [rosl_pkg::NUM_W-1:0]       num_m;
  logic                                    div_start;
  logic signed [rosl_pkg::NUM_W-1:0]       div_num;
  rosl_pkg::div_resp_t                     div_resp;
  logic signed [rosl_pkg::T_W-1:0]         t_lo;
  logic signed [rosl_pkg::T_W-1:0]         t_hi;
  logic signed [rosl_pkg::T_W-1:0]         near_new;
  logic signed [rosl_pkg::T_W-1:0]         far_new;
  logic                                    in_acc;
  logic                                    out_free;
  logic                                    cfg_wr;
  logic                                    reg_sel;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !(out_valid_r && out_stall);

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[rosl_pkg::PADDR_W-1:2] == rosl_pkg::REG_EPS);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {{(rosl_pkg::PDATA_W - rosl_pkg::EPS_W){1'b0}}, eps_r} : '0;

  // operand select for the shared multiplier: three to_center terms, then three ray_dir terms
  always_comb begin
    case (step_r)
      3'd0:    begin op_a = item_r.axis_x; op_b = item_r.to_center_x; end
      3'd1:    begin op_a = item_r.axis_y; op_b = item_r.to_center_y; end
      3'd2:    begin op_a = item_r.axis_z; op_b = item_r.to_center_z; end
      3'd3:    begin op_a = item_r.axis_x; op_b = item_r.ray_dir_x;   end
      3'd4:    begin op_a = item_r.axis_y; op_b = item_r.ray_dir_y;   end
      3'd5:    begin op_a = item_r.axis_z; op_b = item_r.ray_dir_z;   end
      default: begin op_a = item_r.axis_x; op_b = item_r.to_center_x; end
    endcase
  end

  assign dot_ctrl.en  = (state_r == ST_DOT);
  assign dot_ctrl.clr = (step_r == 3'd0) || (step_r == 3'd3);

  rosl_dot_unit u_dot (
    .clk  (clk),
    .ctrl (dot_ctrl),
    .a    (op_a),
    .b    (op_b),
    .dot  (dot_val)
  );

  // f is held in the accumulator from the decide state until both quotients are done
  assign f_mag = dot_val[rosl_pkg::DOT_W-1] ? rosl_pkg::DOT_W'(-dot_val)
                                            : rosl_pkg::DOT_W'(dot_val);
  assign steep = f_mag > {{(rosl_pkg::DOT_W - rosl_pkg::EPS_W){1'b0}}, eps_r};

  assign e_ext = $signed({{(rosl_pkg::NUM_W - rosl_pkg::DOT_W){e_r[rosl_pkg::DOT_W-1]}}, e_r});
  assign h_ext = $signed({{(rosl_pkg::NUM_W - rosl_pkg::H_W){1'b0}}, item_r.half_extent});
  assign num_p = e_ext + h_ext;
  assign num_m = e_ext - h_ext;

  assign div_start = ((state_r == ST_DECIDE) && steep) ||
                     ((state_r == ST_DIV1) && div_resp.done);
  assign div_num   = (state_r == ST_DIV1) ? num_m : num_p;

  rosl_div_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dot_val),
    .resp  (div_resp)
  );

  // interval narrowing
  assign t_lo     = (q1_r > q2_r) ? q2_r : q1_r;
  assign t_hi     = (q1_r > q2_r) ? q1_r : q2_r;
  assign near_new = (t_lo > near_r) ? t_lo : near_r;
  assign far_new  = (t_hi < far_r) ? t_hi : far_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = missed_r ? ST_FINISH : ST_DOT;
      ST_DOT:    if (step_r == 3'd5) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = steep ? ST_DIV1 : ST_FINISH;
      ST_DIV1:   if (div_resp.done) state_nxt = ST_DIV2;
      ST_DIV2:   if (div_resp.done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: if (!item_r.last_axis || out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      near_r      <= '0;
      far_r       <= rosl_pkg::T_MAX;
      missed_r    <= 1'b0;
      eps_r       <= rosl_pkg::EPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        eps_r <= pwdata[rosl_pkg::EPS_W-1:0];
      end
      if (in_acc) begin
        step_r <= '0;
      end else if (state_r == ST_DOT) begin
        step_r <= step_r + 1'b1;
      end
      if ((state_r == ST_DECIDE) && !steep && ((num_p < 0) || (num_m > 0))) begin
        missed_r <= 1'b1;
      end
      if (state_r == ST_UPDATE) begin
        near_r <= near_new;
        far_r  <= far_new;
        if ((near_new > far_new) || (far_new < 0)) begin
          missed_r <= 1'b1;
        end
      end
      if ((state_r == ST_FINISH) && item_r.last_axis && out_free) begin
        out_valid_r <= 1'b1;
        near_r      <= '0;
        far_r       <= rosl_pkg::T_MAX;
        missed_r    <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if ((state_r == ST_DOT) && (step_r == 3'd3)) begin
      e_r <= dot_val;
    end
    if ((state_r == ST_DIV1) && div_resp.done) begin
      q1_r <= div_resp.quo;
    end
    if ((state_r == ST_DIV2) && div_resp.done) begin
      q2_r <= div_resp.quo;
    end
    if ((state_r == ST_FINISH) && item_r.last_axis && out_free) begin
      out_r.hit    <= !missed_r;
      out_r.t_near <= near_r;
      out_r.t_far  <= far_r;
    end
  end

  // a live interval is never empty and never lies behind the origin
  a_interval_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !missed_r |-> ((near_r <= far_r) && (far_r >= 0)))
    else $error("interval inconsistent while box not missed");

  // an axis after a miss skips all arithmetic
  a_miss_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && missed_r) |=> (state_r == ST_FINISH))
    else $error("axis after a miss was not skipped");

  // quotients come back only while the sequencer waits for them
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_resp.done |-> ((state_r == ST_DIV1) || (state_r == ST_DIV2)))
    else $error("divider finished outside a divide state");

  // emitting a result restarts the interval
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && item_r.last_axis && out_free) |=>
      (out_valid_r && !missed_r && (near_r == 0) && (far_r == rosl_pkg::T_MAX)))
    else $error("result load did not restart the interval");

endmodule

>>> verif/ray_obb_slab_test_top_tb.sv
// testbench for the ray against oriented box slab test: random boxes, register phases, checking
`timescale 1ns / 1ps

module ray_obb_slab_test_top_tb;

  localparam int FRAC = 16;
  localparam int ONE = 1 << FRAC;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 2000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rosl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rosl_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rosl_pkg::PADDR_W-1:0] paddr = '0;
  logic [rosl_pkg::PDATA_W-1:0] pwdata = '0;
  logic [rosl_pkg::PDATA_W-1:0] prdata;
  logic pready;

  rosl_pkg::in_item_t pending_items[$];
  rosl_pkg::out_item_t expected_boxes[$];

  // running slab interval of the box in flight
  longint slab_near = 0;
  longint slab_far = Q_MAX;
  logic slab_missed = 1'b0;
  logic [rosl_pkg::EPS_W-1:0] eps_model = rosl_pkg::EPS_RESET;

  int queued_items = 0;
  int items_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic in_fire = 1'b0;
  logic box_open = 1'b0;
  logic calm;

  ray_obb_slab_test_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // no idling on either side over this stretch of items
  assign calm = (items_taken >= 500) && (items_taken < 800);

  function automatic longint clip_quot(longint num, longint den);
    longint q;
    q = (num * (longint'(1) << FRAC)) / den;
    if (q > Q_MAX) q = Q_MAX;
    if (q < Q_MIN) q = Q_MIN;
    return q;
  endfunction

  task automatic predict_slab(input rosl_pkg::in_item_t it);
    longint e, f, fmag, h, t1, t2, swap_t;
    rosl_pkg::out_item_t res;
    h = longint'(it.half_extent);
    if (!slab_missed) begin
      e = (longint'($signed(it.axis_x)) * longint'($signed(it.to_center_x)) +
           longint'($signed(it.axis_y)) * longint'($signed(it.to_center_y)) +
           longint'($signed(it.axis_z)) * longint'($signed(it.to_center_z)))
          >>> rosl_pkg::AXIS_FRAC;
      f = (longint'($signed(it.axis_x)) * longint'($signed(it.ray_dir_x)) +
           longint'($signed(it.axis_y)) * longint'($signed(it.ray_dir_y)) +
           longint'($signed(it.axis_z)) * longint'($signed(it.ray_dir_z)))
          >>> rosl_pkg::AXIS_FRAC;
      fmag = (f < 0) ? -f : f;
      if (fmag > longint'(eps_model)) begin
        t1 = clip_quot(e + h, f);
        t2 = clip_quot(e - h, f);
        if (t1 > t2) begin
          swap_t = t1;
          t1 = t2;
          t2 = swap_t;
        end
        if (t1 > slab_near) slab_near = t1;
        if (t2 < slab_far) slab_far = t2;
        if (slab_near > slab_far || slab_far < 0) slab_missed = 1'b1;
      end else if (e < -h || e > h) begin
        slab_missed = 1'b1;
      end
    end
    if (it.last_axis) begin
      res.hit = !slab_missed;
      res.t_near = slab_near[rosl_pkg::T_W-1:0];
      res.t_far = slab_far[rosl_pkg::T_W-1:0];
      expected_boxes.insert(expected_boxes.size(), res);
      slab_near = 0;
      slab_far = Q_MAX;
      slab_missed = 1'b0;
    end
  endtask

  function automatic rosl_pkg::in_item_t slab_item(int ax, int ay, int az, int h,
                                                   int cx, int cy, int cz,
                                                   int dx, int dy, int dz,
                                                   logic last);
    rosl_pkg::in_item_t it;
    it.axis_x = ax[rosl_pkg::AXIS_W-1:0];
    it.axis_y = ay[rosl_pkg::AXIS_W-1:0];
    it.axis_z = az[rosl_pkg::AXIS_W-1:0];
    it.half_extent = h[rosl_pkg::H_W-1:0];
    it.to_center_x = cx;
    it.to_center_y = cy;
    it.to_center_z = cz;
    it.ray_dir_x = dx;
    it.ray_dir_y = dy;
    it.ray_dir_z = dz;
    it.last_axis = last;
    return it;
  endfunction

  function automatic int span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic queue_item(input rosl_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
    queued_items++;
    box_open = !it.last_axis;
  endtask

  // a real box: orthonormal axes, shared center and direction, sometimes odd length
  task automatic push_box();
    int basis[3][3];
    int tc[3];
    int dir[3];
    int n_axes, rot, c, s, sh, a, j, sgn;
    real ang;
    ang = $urandom_range(0, 6283) / 1000.0;
    c = $rtoi(32767.0 * $cos(ang));
    s = $rtoi(32767.0 * $sin(ang));
    if ($urandom_range(0, 3) == 0) begin
      c = 32767;
      s = 0;
    end
    rot = $urandom_range(0, 2);
    basis[0][rot] = c;
    basis[0][(rot + 1) % 3] = s;
    basis[0][(rot + 2) % 3] = 0;
    basis[1][rot] = -s;
    basis[1][(rot + 1) % 3] = c;
    basis[1][(rot + 2) % 3] = 0;
    basis[2][rot] = 0;
    basis[2][(rot + 1) % 3] = 0;
    basis[2][(rot + 2) % 3] = 32767;
    for (j = 0; j < 3; j++) tc[j] = span(1 << 23);
    sh = $urandom_range(0, 3);
    // half the rays aim roughly at the center so that hits are common
    if ($urandom_range(0, 1)) begin
      for (j = 0; j < 3; j++) dir[j] = (tc[j] >>> sh) + span(1 << 14);
    end else begin
      for (j = 0; j < 3; j++) dir[j] = span(1 << 17);
    end
    if ($urandom_range(0, 6) == 0) dir[$urandom_range(0, 2)] = 0;
    n_axes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 3;
    for (a = 0; a < n_axes; a++) begin
      sgn = $urandom_range(0, 1) ? -1 : 1;
      queue_item(slab_item(sgn * basis[a % 3][0], sgn * basis[a % 3][1],
                           sgn * basis[a % 3][2], $urandom_range(0, 1 << 22),
                           tc[0], tc[1], tc[2], dir[0], dir[1], dir[2],
                           a == n_axes - 1));
    end
  endtask

  task automatic push_noise(input logic force_last);
    rosl_pkg::in_item_t it;
    it.axis_x = 16'($urandom);
    it.axis_y = 16'($urandom);
    it.axis_z = 16'($urandom);
    it.half_extent = 31'($urandom);
    it.to_center_x = $urandom;
    it.to_center_y = $urandom;
    it.to_center_z = $urandom;
    it.ray_dir_x = $urandom;
    it.ray_dir_y = $urandom;
    it.ray_dir_z = $urandom;
    it.last_axis = force_last | 1'($urandom_range(0, 1));
    queue_item(it);
  endtask

  task automatic push_directed();
    // box on the coordinate axes straight ahead
    queue_item(slab_item(32767, 0, 0, ONE, 5 * ONE, 0, 0, ONE, 0, 0, 1'b0));
    queue_item(slab_item(0, 32767, 0, ONE, 5 * ONE, 0, 0, ONE, 0, 0, 1'b0));
    queue_item(slab_item(0, 0, 32767, ONE, 5 * ONE, 0, 0, ONE, 0, 0, 1'b1));
    // parallel slab outside the box, later axes ignored
    queue_item(slab_item(0, 32767, 0, ONE, 0, 3 * ONE, 0, ONE, 0, 0, 1'b0));
    queue_item(slab_item(32767, 0, 0, ONE, 0, 3 * ONE, 0, ONE, 0, 0, 1'b0));
    queue_item(slab_item(0, 0, 32767, ONE, 0, 3 * ONE, 0, ONE, 0, 0, 1'b1));
    // box behind the ray, both ways
    queue_item(slab_item(32767, 0, 0, ONE, -5 * ONE, 0, 0, ONE, 0, 0, 1'b1));
    queue_item(slab_item(32767, 0, 0, ONE, 5 * ONE, 0, 0, -ONE, 0, 0, 1'b1));
    // |f| right at the parallel bound, then just above it
    queue_item(slab_item(16384, 0, 0, ONE, 0, 0, 0, 132, 0, 0, 1'b0));
    queue_item(slab_item(16384, 0, 0, ONE, 0, 0, 0, 134, 0, 0, 1'b1));
    // extremes and saturated quotients
    queue_item(slab_item(-32768, -32768, -32768, 32'h7FFF_FFFF, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
    queue_item(slab_item(32767, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 100, 0, 0, 1'b1));
    queue_item(slab_item(32767, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, -100, 0, 0, 1'b1));
    queue_item(slab_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // five-axis box with diagonal axes
    queue_item(slab_item(23170, 23170, 0, ONE, 2 * ONE, 2 * ONE, 0, ONE, ONE, 0, 1'b0));
    queue_item(slab_item(-23170, 23170, 0, ONE, 2 * ONE, 2 * ONE, 0, ONE, ONE, 0, 1'b0));
    queue_item(slab_item(0, 0, -32768, ONE, 2 * ONE, 2 * ONE, 0, ONE, ONE, 0, 1'b0));
    queue_item(slab_item(32767, 0, 0, ONE, 2 * ONE, 2 * ONE, 0, ONE, ONE, 0, 1'b0));
    queue_item(slab_item(-1, -1, -1, 1, -1, -1, -1, -1, -1, -1, 1'b1));
  endtask

  task automatic apb_access(input logic wr, input logic [rosl_pkg::PADDR_W-1:0] addr,
                            input logic [rosl_pkg::PDATA_W-1:0] wdata,
                            output logic [rosl_pkg::PDATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == 40) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
    end
  end

  // prediction on accepted items, checking of accepted results
  always @(posedge clk) begin
    rosl_pkg::out_item_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_slab(in_data);
      items_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_boxes.size() == 0) begin
        $error("unexpected result hit=%0d t_near=%0d t_far=%0d",
               out_data.hit, out_data.t_near, out_data.t_far);
        mismatches++;
      end else begin
        want = expected_boxes.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit expected %0d actual %0d", want.hit, out_data.hit);
          mismatches++;
        end
        if (out_data.t_near !== want.t_near) begin
          $error("t_near expected %0d actual %0d", want.t_near, out_data.t_near);
          mismatches++;
        end
        if (out_data.t_far !== want.t_far) begin
          $error("t_far expected %0d actual %0d", want.t_far, out_data.t_far);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [rosl_pkg::EPS_W-1:0] eps_plan[5];
    logic [rosl_pkg::PDATA_W-1:0] readback;
    int p, start;
    eps_plan[0] = rosl_pkg::EPS_RESET;
    eps_plan[1] = '0;
    eps_plan[2] = '1;
    eps_plan[3] = 16'($urandom_range(1, 65534));
    eps_plan[4] = 16'd300;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < 5; p++) begin
      // block is idle here: nothing queued, nothing in flight
      apb_access(1'b1, {rosl_pkg::REG_EPS, 2'b00},
                 {{(rosl_pkg::PDATA_W - rosl_pkg::EPS_W){1'b0}}, eps_plan[p]}, readback);
      eps_model = eps_plan[p];
      apb_access(1'b0, {rosl_pkg::REG_EPS, 2'b00}, '0, readback);
      if (readback[rosl_pkg::EPS_W-1:0] !== eps_plan[p]) begin
        $error("parallel_epsilon expected %0d actual %0d", eps_plan[p],
               readback[rosl_pkg::EPS_W-1:0]);
        mismatches++;
      end
      start = queued_items;
      if (p == 0) push_directed();
      while (queued_items - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) push_box();
        else push_noise(1'b0);
      end
      if (box_open) push_noise(1'b1);
      while (pending_items.size() != 0 || in_valid || expected_boxes.size() != 0)
        @(posedge clk);
      // margin so that the block is back in idle before the next register write
      repeat (100) @(posedge clk);
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
